/* src/assert_macros.svh */
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define NNS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define NNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NNS_ASSERT_IMP(lbl, ante, cons, msg)
`define NNS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* src/nns_pkg.sv */
// types and constants for the nearest-neighbour search block
package nns_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int MAX_DIMS   = 16;

    localparam int COORD_W = 16;
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int DIM_W   = $clog2(MAX_DIMS);
    localparam int POS_W   = $clog2(MAX_DIMS + 1);
    localparam int ADDR_W  = IDX_W + DIM_W;
    localparam int SQ_W    = 2 * (COORD_W + 1);
    localparam int DIST_W  = 36;
    localparam int OIDX_W  = 10;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] coord;
        logic                      last;
    } t_in_item;

    typedef struct packed {
        logic [OIDX_W-1:0] nearest_index;
        logic [DIST_W-1:0] best_dist_sq;
        logic              empty_res;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic fill;
        logic scan;
        logic emit;
        logic emit_empty;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic fill_need;
        logic scan_need;
        logic query_empty;
        logic fill_last;
        logic issue_last;
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

/* src/nns_ctrl.sv */
// controller state machine for the nearest-neighbour search
`include "assert_macros.svh"

module nns_ctrl
    import nns_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FILL   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_EMIT_E = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    if (i_status.fill_need) begin
                        n_state = ST_FILL;
                    end else if (i_status.scan_need) begin
                        n_state = ST_SCAN;
                    end else if (i_status.query_empty) begin
                        n_state = ST_EMIT_E;
                    end
                end
            end
            ST_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_status.scan_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_EMIT_E: begin
                if (i_status.out_free) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

    `NNS_ASSERT_IMP(a_done_in_drain, i_status.scan_done, r_state == ST_DRAIN, "scan done outside drain")
    `NNS_ASSERT_IMP(a_emit_when_free, o_cmd.emit || o_cmd.emit_empty, i_status.out_free, "emit into full output")
    `NNS_ASSERT_NEXT(a_scan_exit, r_state == ST_SCAN, r_state == ST_SCAN || r_state == ST_DRAIN, "scan left early")

endmodule

/* src/nns_dp.sv */
// datapath: point store, query buffer, distance pipeline and result register
`include "assert_macros.svh"

module nns_dp
    import nns_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [POS_W-1:0] i_cfg_data,
    input  t_in_item         i_item,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_item        o_item
);

    // configuration and bookkeeping
    logic [POS_W-1:0] r_num_dims;
    logic [CNT_W-1:0] r_count;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] dims;
    logic [DIM_W-1:0] dims_m1;
    logic [POS_W-1:0] pos_n;
    logic             pos_lt;
    logic             room;
    logic             acc_load;
    logic             acc_query;
    logic             acc_clear;

    // point store
    logic [COORD_W-1:0] r_mem [MAX_POINTS*MAX_DIMS];
    logic [COORD_W-1:0] r_rd;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [COORD_W-1:0] mem_wd;
    logic [IDX_W-1:0]   r_fill_row;
    logic [DIM_W-1:0]   r_fill_pos;

    // query buffer
    logic [COORD_W-1:0] r_q [MAX_DIMS];

    // scan counters and pipeline
    logic [IDX_W-1:0]   r_sp;
    logic [DIM_W-1:0]   r_sd;
    logic               issue_lastd;
    logic               issue_end;
    logic               r_s1_v, r_s1_first, r_s1_lastd, r_s1_end;
    logic [IDX_W-1:0]   r_s1_idx;
    logic [COORD_W-1:0] r_s1_q;
    logic               r_s2_v, r_s2_first, r_s2_lastd, r_s2_end;
    logic [IDX_W-1:0]   r_s2_idx;
    logic [SQ_W-1:0]    r_s2_sq;
    logic               r_s3_v, r_s3_lastd, r_s3_end;
    logic [IDX_W-1:0]   r_s3_idx;
    logic [DIST_W-1:0]  r_acc;
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]   mag;
    logic [DIST_W:0]    sum;
    logic [DIST_W-1:0]  sum_sat;
    logic [DIST_W-1:0]  r_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_done;

    // result register
    logic               r_o_valid;
    t_out_item          r_o_item;

    always_comb begin
        if (r_num_dims == '0) begin
            dims = POS_W'(1);
        end else if (r_num_dims > POS_W'(MAX_DIMS)) begin
            dims = POS_W'(MAX_DIMS);
        end else begin
            dims = r_num_dims;
        end
    end

    assign dims_m1   = DIM_W'(dims - POS_W'(1));
    assign pos_lt    = (r_pos < dims);
    assign pos_n     = pos_lt ? (r_pos + POS_W'(1)) : r_pos;
    assign room      = (r_count < CNT_W'(MAX_POINTS));
    assign acc_load  = i_cmd.accept && (i_item.kind == KIND_LOAD);
    assign acc_query = i_cmd.accept && (i_item.kind == KIND_QUERY);
    assign acc_clear = i_cmd.accept && (i_item.kind == KIND_CLEAR);

    always_comb begin
        o_status             = '0;
        o_status.fill_need   = (i_item.kind == KIND_LOAD) && i_item.last && room
                               && (pos_n < POS_W'(MAX_DIMS));
        o_status.scan_need   = (i_item.kind == KIND_QUERY) && i_item.last && (r_count != '0);
        o_status.query_empty = (i_item.kind == KIND_QUERY) && i_item.last && (r_count == '0);
        o_status.fill_last   = (r_fill_pos == DIM_W'(MAX_DIMS - 1));
        o_status.issue_last  = issue_end;
        o_status.scan_done   = r_done;
        o_status.out_free    = !r_o_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= POS_W'(2);
            r_count    <= '0;
            r_pos      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_num_dims <= i_cfg_data;
            end
            if (acc_clear) begin
                r_count <= '0;
                r_pos   <= '0;
            end else if (acc_load || acc_query) begin
                r_pos <= i_item.last ? '0 : pos_n;
                if (acc_load && i_item.last && room) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // zero fill of the rest of a short point, one slot a cycle
    always_ff @(posedge i_clk) begin
        if (acc_load && i_item.last) begin
            r_fill_row <= r_count[IDX_W-1:0];
            r_fill_pos <= pos_n[DIM_W-1:0];
        end else if (i_cmd.fill) begin
            r_fill_pos <= r_fill_pos + DIM_W'(1);
        end
    end

    assign mem_we = (acc_load && room && pos_lt) || i_cmd.fill;
    assign mem_wa = i_cmd.fill ? {r_fill_row, r_fill_pos}
                               : {r_count[IDX_W-1:0], r_pos[DIM_W-1:0]};
    assign mem_wd = i_cmd.fill ? '0 : i_item.coord;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[{r_sp, r_sd}];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_DIMS; i++) begin
            if (acc_query) begin
                if (pos_lt && (r_pos == POS_W'(i))) begin
                    r_q[i] <= i_item.coord;
                end else if (i_item.last && (POS_W'(i) >= pos_n)) begin
                    r_q[i] <= '0;
                end
            end
        end
    end

    // scan address generation
    assign issue_lastd = (r_sd == dims_m1);
    assign issue_end   = i_cmd.scan && issue_lastd
                         && ({1'b0, r_sp} == (r_count - CNT_W'(1)));

    always_ff @(posedge i_clk) begin
        if (acc_query) begin
            r_sp <= '0;
            r_sd <= '0;
        end else if (i_cmd.scan) begin
            if (issue_lastd) begin
                r_sd <= '0;
                r_sp <= r_sp + IDX_W'(1);
            end else begin
                r_sd <= r_sd + DIM_W'(1);
            end
        end
    end

    // pipeline payload
    assign diff = $signed({r_s1_q[COORD_W-1], r_s1_q}) - $signed({r_rd[COORD_W-1], r_rd});
    assign mag  = diff[COORD_W] ? (COORD_W+1)'(0) - diff : diff;
    assign sum  = (r_s2_first ? '0 : {1'b0, r_acc}) + (DIST_W+1)'(r_s2_sq);
    assign sum_sat = sum[DIST_W] ? '1 : sum[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        r_s1_first <= (r_sd == '0);
        r_s1_lastd <= issue_lastd;
        r_s1_end   <= issue_end;
        r_s1_idx   <= r_sp;
        r_s1_q     <= r_q[r_sd];

        r_s2_first <= r_s1_first;
        r_s2_lastd <= r_s1_lastd;
        r_s2_end   <= r_s1_end;
        r_s2_idx   <= r_s1_idx;
        r_s2_sq    <= mag * mag;

        r_s3_lastd <= r_s2_lastd;
        r_s3_end   <= r_s2_end;
        r_s3_idx   <= r_s2_idx;
        if (r_s2_v) begin
            r_acc <= sum_sat;
        end

        // strict compare keeps the lowest index on ties
        if (r_s3_v && r_s3_lastd) begin
            if ((r_s3_idx == '0) || (r_acc < r_best)) begin
                r_best     <= r_acc;
                r_best_idx <= r_s3_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_done    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.scan;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_done <= r_s3_v && r_s3_lastd && r_s3_end;
            if (i_cmd.emit || i_cmd.emit_empty) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_item.nearest_index <= OIDX_W'(r_best_idx);
            r_o_item.best_dist_sq  <= r_best;
            r_o_item.empty_res     <= 1'b0;
        end else if (i_cmd.emit_empty) begin
            r_o_item <= '{nearest_index: '0, best_dist_sq: '0, empty_res: 1'b1};
        end
    end

    assign o_valid = r_o_valid;
    assign o_item  = r_o_item;

    `NNS_ASSERT_IMP(a_pos_range, 1'b1, r_pos <= POS_W'(MAX_DIMS), "position beyond dimension")
    `NNS_ASSERT_IMP(a_count_range, 1'b1, r_count <= CNT_W'(MAX_POINTS), "point count overflow")
    `NNS_ASSERT_IMP(a_best_in_store, r_done, {1'b0, r_best_idx} < r_count, "best index not stored")
    `NNS_ASSERT_NEXT(a_emit_loads, i_cmd.emit || i_cmd.emit_empty, r_o_valid, "result not presented")

endmodule

/* src/nearest_neighbor_search.sv */
// top level of the nearest-neighbour search block
//
// input channel: i_valid / o_stall carrying i_item (kind, coord, last).
// kind load stores one coordinate of a reference point, kind query one
// coordinate of the query point, kind clear empties the store; last closes
// a point. output channel: o_valid / i_stall carrying o_item, one item per
// finished query: index and squared distance of the closest point, or the
// empty flag when nothing is stored.
// i_cfg_we / i_cfg_data write num_dims; write it only while the block is idle.
// a load point closed early is zero-filled in its remaining slots, one slot
// per cycle, up to 15 slots. a finished query scans every stored point, one
// coordinate read from the point store per cycle, at most 1024 points of 16
// coordinates, then drains the pipeline and hands the result off. a query
// on an empty store answers through the empty-result state once the output
// register is free.
// o_stall is high while a fill, scan or result hand-off is running.
// the result register is separate from the input side, so loads are taken
// while a result waits; a query that finishes then waits for it to drain.
// synchronous reset empties the store, clears the position and sets num_dims
// to 2; point store contents are not cleared.
module nearest_neighbor_search
    import nns_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [POS_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_item         i_item,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_item        o_item
);

    t_cmd    cmd;
    t_status status;

    nns_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    nns_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

endmodule

/* tb/nearest_neighbor_search_test.sv */
// self-checking testbench for the nearest-neighbour search block
module nearest_neighbor_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nns_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int SEGMENTS       = 6;
    localparam int SEGMENT_ITEMS  = 48;
    localparam int FILL_POINTS    = MAX_POINTS + 6;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam longint unsigned DIST_LIMIT = (64'd1 << DIST_W) - 1;
    localparam t_out_item NO_ANSWER = '0;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_step_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [POS_W-1:0] i_cfg_data;
    logic             i_valid;
    logic             o_stall;
    t_in_item         i_item;
    logic             o_valid;
    logic             i_stall;
    t_out_item        o_item;

    // shadow copy of the block state
    logic signed [COORD_W-1:0] store_coord [MAX_POINTS][MAX_DIMS];
    bit                        store_set   [MAX_POINTS][MAX_DIMS];
    logic signed [COORD_W-1:0] query_coord [MAX_DIMS];
    int unsigned               store_count;
    int unsigned               coord_pos;
    logic [POS_W-1:0]          dims_reg;

    t_out_item answers_due[$];
    int        mismatches = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        quiet_cycles = 0;

    int unsigned seg_dims   [SEGMENTS] = '{16, 1, 31, 0, 5, 2};
    int          seg_idle   [4]        = '{0, 76, 0, 16};
    int          seg_stall  [4]        = '{0, 0, 76, 16};

    t_step_row directed_rows [24] = '{
        '{t_in_item'{KIND_QUERY, 16'sh1234, 1'b0}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_QUERY, -16'sd5, 1'b1}, 1'b1, t_out_item'{10'd0, 36'd0, 1'b1}},
        '{t_in_item'{KIND_LOAD, 16'sh7FFF, 1'b0}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_LOAD, 16'sh7FFF, 1'b1}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_QUERY, 16'sh8000, 1'b0}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_QUERY, 16'sh8000, 1'b1}, 1'b1,
          t_out_item'{10'd0, 36'd8589672450, 1'b0}},
        '{t_in_item'{KIND_UNUSED, 16'sh5555, 1'b1}, 1'b0, NO_ANSWER},
        // short point, second coordinate zero
        '{t_in_item'{KIND_LOAD, 16'sh8000, 1'b1}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_QUERY, 16'sh8000, 1'b1}, 1'b1, t_out_item'{10'd1, 36'd0, 1'b0}},
        '{t_in_item'{KIND_LOAD, 16'sd100, 1'b0}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_LOAD, 16'sd200, 1'b0}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_LOAD, 16'sd300, 1'b0}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_LOAD, 16'sd400, 1'b1}, 1'b0, NO_ANSWER},
        // kinds swapped part way through a point
        '{t_in_item'{KIND_LOAD, 16'sd7, 1'b0}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_QUERY, -16'sd7, 1'b1}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_QUERY, 16'sd50, 1'b0}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_LOAD, 16'sd60, 1'b1}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_QUERY, 16'sd7, 1'b0}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_QUERY, 16'sd60, 1'b1}, 1'b1, t_out_item'{10'd3, 36'd0, 1'b0}},
        '{t_in_item'{KIND_CLEAR, 16'sd0, 1'b0}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_QUERY, 16'sd1, 1'b1}, 1'b1, t_out_item'{10'd0, 36'd0, 1'b1}},
        // equal distances, lowest index must win
        '{t_in_item'{KIND_LOAD, 16'sd5, 1'b1}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_LOAD, 16'sd5, 1'b1}, 1'b0, NO_ANSWER},
        '{t_in_item'{KIND_QUERY, 16'sd5, 1'b1}, 1'b1, t_out_item'{10'd0, 36'd0, 1'b0}}
    };

    nearest_neighbor_search uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic int unsigned dims_in_force();
        if (dims_reg == 0) return 1;
        if (dims_reg > MAX_DIMS) return MAX_DIMS;
        return int'(dims_reg);
    endfunction

    // advances the shadow state by one item; ans is valid when got is set
    function automatic void track_item(input t_in_item it, output bit got,
                                       output t_out_item ans);
        int unsigned dims, p, d, best_idx;
        longint unsigned sum, best;
        int diff;
        bit room;
        dims = dims_in_force();
        got = 1'b0;
        ans = '0;
        case (it.kind)
            KIND_CLEAR: begin
                store_count = 0;
                coord_pos = 0;
            end
            KIND_LOAD: begin
                room = store_count < MAX_POINTS;
                if (room && coord_pos < dims) begin
                    store_coord[store_count][coord_pos] = it.coord;
                    store_set[store_count][coord_pos] = 1'b1;
                end
                if (coord_pos < dims) coord_pos++;
                if (it.last) begin
                    if (room) begin
                        for (d = coord_pos; d < MAX_DIMS; d++) begin
                            store_coord[store_count][d] = '0;
                            store_set[store_count][d] = 1'b1;
                        end
                        store_count++;
                    end
                    coord_pos = 0;
                end
            end
            KIND_QUERY: begin
                if (coord_pos < dims) begin
                    query_coord[coord_pos] = it.coord;
                    coord_pos++;
                end
                if (it.last) begin
                    for (d = coord_pos; d < MAX_DIMS; d++) query_coord[d] = '0;
                    coord_pos = 0;
                    got = 1'b1;
                    if (store_count == 0) begin
                        ans.empty_res = 1'b1;
                    end else begin
                        best = 0;
                        best_idx = 0;
                        for (p = 0; p < store_count; p++) begin
                            sum = 0;
                            for (d = 0; d < dims; d++) begin
                                diff = int'(query_coord[d]) - int'(store_coord[p][d]);
                                sum += longint'(diff) * longint'(diff);
                                if (sum > DIST_LIMIT) sum = DIST_LIMIT;
                            end
                            if (p == 0 || sum < best) begin
                                best = sum;
                                best_idx = p;
                            end
                        end
                        ans.nearest_index = best_idx[OIDX_W-1:0];
                        ans.best_dist_sq = best[DIST_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // a load that would close a point over never-written slots becomes a query
    function automatic t_in_item avoid_unset_slots(input t_in_item it);
        int unsigned dims, new_pos, d;
        dims = dims_in_force();
        new_pos = (coord_pos < dims) ? coord_pos + 1 : coord_pos;
        if (it.kind == KIND_LOAD && it.last && store_count < MAX_POINTS) begin
            for (d = 0; d < new_pos; d++) begin
                if (d != coord_pos && !store_set[store_count][d]) it.kind = KIND_QUERY;
            end
        end
        return it;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int v;
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: begin
                v = int'($urandom_range(16)) - 8;
                return v[COORD_W-1:0];
            end
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic send_item(input t_in_item it, input bit typed = 1'b0,
                             input t_out_item want = '0);
        bit got;
        t_out_item ans;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_stall);
        track_item(it, got, ans);
        if (got) answers_due.insert(answers_due.size(), typed ? want : ans);
    endtask

    // closes any open point, then holds off until every answer is back
    task automatic settle_block();
        if (coord_pos != 0) send_item(avoid_unset_slots(t_in_item'{KIND_LOAD, 16'sd0, 1'b1}));
        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [POS_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dims_reg = value;
    endtask

    task automatic random_traffic(input int unsigned quota);
        int unsigned taken, len, i, pick;
        logic [1:0] base_kind;
        t_in_item it;
        taken = 0;
        while (taken < quota) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_item(t_in_item'{KIND_CLEAR, rand_coord(), 1'($urandom_range(1))});
                taken++;
            end else if (pick < 8) begin
                // ignored by the block, so not counted
                send_item(t_in_item'{KIND_UNUSED, rand_coord(), 1'($urandom_range(1))});
            end else begin
                base_kind = ($urandom_range(99) < 65) ? KIND_LOAD : KIND_QUERY;
                len = dims_in_force();
                pick = $urandom_range(9);
                if (pick == 0) len = $urandom_range(len, 1);
                else if (pick == 1) len = len + $urandom_range(2, 1);
                for (i = 0; i < len; i++) begin
                    it.kind = base_kind;
                    if ($urandom_range(99) < 5)
                        it.kind = (base_kind == KIND_LOAD) ? KIND_QUERY : KIND_LOAD;
                    it.coord = rand_coord();
                    it.last = (i == len - 1);
                    send_item(avoid_unset_slots(it));
                    taken++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item due;
        if (i_rst_n === 1'b1 && o_valid && !i_stall) begin
            if (answers_due.size() == 0) begin
                $error("unexpected result: index %0d dist %0d empty %0b",
                       o_item.nearest_index, o_item.best_dist_sq, o_item.empty_res);
                mismatches++;
            end else begin
                due = answers_due.pop_front();
                if (o_item.nearest_index !== due.nearest_index) begin
                    $error("nearest_index: expected %0d, got %0d",
                           due.nearest_index, o_item.nearest_index);
                    mismatches++;
                end
                if (o_item.best_dist_sq !== due.best_dist_sq) begin
                    $error("best_dist_sq: expected %0d, got %0d",
                           due.best_dist_sq, o_item.best_dist_sq);
                    mismatches++;
                end
                if (o_item.empty_res !== due.empty_res) begin
                    $error("empty_res: expected %0b, got %0b",
                           due.empty_res, o_item.empty_res);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned p, q, row, seg;
        for (p = 0; p < MAX_POINTS; p++) begin
            for (q = 0; q < MAX_DIMS; q++) store_coord[p][q] = '0;
        end
        for (q = 0; q < MAX_DIMS; q++) query_coord[q] = '0;
        store_count = 0;
        coord_pos = 0;
        dims_reg = 5'd2;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_item = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 16;
        stall_pct = 16;
        for (row = 0; row < 24; row++)
            send_item(directed_rows[row].item, directed_rows[row].typed,
                      directed_rows[row].want);

        // fill the store past its size with one coordinate per point
        settle_block();
        idle_pct = 0;
        stall_pct = 0;
        set_dims(5'd1);
        send_item(t_in_item'{KIND_CLEAR, 16'sd0, 1'b1});
        for (p = 0; p < FILL_POINTS; p++)
            send_item(t_in_item'{KIND_LOAD,
                      (p < MAX_POINTS) ? 16'(p * 32 - 16384) : 16'sh7FFF, 1'b1});
        send_item(t_in_item'{KIND_QUERY, 16'sd16352, 1'b1}, 1'b1,
                  t_out_item'{10'd1023, 36'd0, 1'b0});
        send_item(t_in_item'{KIND_QUERY, 16'sh7FFF, 1'b1});
        send_item(t_in_item'{KIND_QUERY, 16'sh8000, 1'b1});
        send_item(t_in_item'{KIND_QUERY, rand_coord(), 1'b1});
        send_item(t_in_item'{KIND_CLEAR, 16'sd0, 1'b0});

        for (seg = 0; seg < SEGMENTS; seg++) begin
            settle_block();
            set_dims(seg_dims[seg][POS_W-1:0]);
            idle_pct = seg_idle[seg % 4];
            stall_pct = seg_stall[seg % 4];
            random_traffic(SEGMENT_ITEMS);
        end

        settle_block();
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
